### rtl/i2cblm_pkg.sv
// Package for the I2C bit-level master: phase codes, command codes,
// phase lengths and the field widths of the stream payloads.
// Used by i2c_bit_level_master; depends on nothing else.
`default_nettype none

package i2cblm_pkg;

  // Phase lengths in ticks
  localparam logic [2:0] SHORT_PHASE_TICKS = 3'd2;
  localparam logic [2:0] LONG_PHASE_TICKS  = 3'd4;

  // Reset value of the ack timeout limit
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [7:0] TIMEOUT_MAX       = 8'hFF;

  // Bits per byte and the bit counter width
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Command codes carried in the mode field
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_WAIT  = 3'd4,
    CMD_READ  = 3'd5,
    CMD_RSV6  = 3'd6,
    CMD_RSV7  = 3'd7
  } cmd_t;

  // Sequencer phases, one-hot
  typedef enum logic [15:0] {
    PH_IDLE  = 16'h0001,
    PH_S1    = 16'h0002,
    PH_S2    = 16'h0004,
    PH_PA    = 16'h0008,
    PH_PB    = 16'h0010,
    PH_PC    = 16'h0020,
    PH_WSET  = 16'h0040,
    PH_WPRE  = 16'h0080,
    PH_WHIGH = 16'h0100,
    PH_ALOW  = 16'h0200,
    PH_APRE  = 16'h0400,
    PH_APOLL = 16'h0800,
    PH_AHOLD = 16'h1000,
    PH_RLOW  = 16'h2000,
    PH_RPRE  = 16'h4000,
    PH_RPOST = 16'h8000
  } phase_t;

  // Stream payload widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  // Ticks spent in a timed phase
  function automatic logic [2:0] phase_length(input phase_t ph);
    logic [2:0] len;
    len = LONG_PHASE_TICKS;
    if (ph == PH_WSET || ph == PH_WPRE || ph == PH_APRE ||
        ph == PH_RPRE || ph == PH_RPOST) begin
      len = SHORT_PHASE_TICKS;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/i2c_bit_level_master.sv
// I2C bit-level master sequencer: one tick per input transfer, one result
// transfer per tick. Depends on i2cblm_pkg.
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tuser mode, s_tdata tick fields
// m_axis    out        m_tvalid/m_tready  m_tdata line levels and status
// cfg       in         cfg_valid/cfg_ready cfg_data ack timeout limit
//
// One tick is taken per clock while s_tready is high; its result appears in the
// output register on the next cycle. The sequencer state and the result register
// update in the same edge, so the throughput is one tick per cycle when not stalled.
// A tick is taken whenever the output register is empty or being drained.
// rst is synchronous and returns the sequencer to idle with SCL and SDA
// released and the limit at 250. cfg_ready is always high.

module i2c_bit_level_master
  import i2cblm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // tick input
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [7:0] tx_byte, [8] send_ack, [9] sda_level, [15:10] zero
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] mode
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  // result output
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] scl_level, [1] sda_release, [2] busy_res, [3] done_res,
  // [11:4] rx_byte, [12] ack_missing, [15:13] zero
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // configuration write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [7:0]            cfg_data
);

  // Sequencer state
  phase_t     phase, phase_next;
  cmd_t       active_cmd, active_cmd_next;
  logic [2:0] phase_ticks, phase_ticks_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_data, shift_data_next;
  logic [7:0] timeout_ticks, timeout_ticks_next;
  logic       ack_choice, ack_choice_next;
  logic       scl_out, scl_out_next;
  logic       sda_out, sda_out_next;
  logic       ack_fail, ack_fail_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       done;
  logic [7:0] ack_timeout_limit;

  // Unpacked input fields
  cmd_t       mode;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_level;
  logic       take;
  logic [2:0] ticks_inc;
  logic [3:0] bit_inc;
  logic [7:0] timeout_inc;

  assign mode      = cmd_t'(s_tuser[2:0]);
  assign tx_byte   = s_tdata[7:0];
  assign send_ack  = s_tdata[8];
  assign sda_level = s_tdata[9];

  assign s_tready  = !m_tvalid || m_tready;
  assign take      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign ticks_inc   = phase_ticks + 3'd1;
  assign bit_inc     = bit_index + 4'd1;
  assign timeout_inc = (timeout_ticks < TIMEOUT_MAX) ? timeout_ticks + 8'd1 : timeout_ticks;

  // Advance the sequencer by one tick
  always_comb begin
    phase_next         = phase;
    active_cmd_next    = active_cmd;
    phase_ticks_next   = phase_ticks;
    bit_index_next     = bit_index;
    shift_data_next    = shift_data;
    timeout_ticks_next = timeout_ticks;
    ack_choice_next    = ack_choice;
    scl_out_next       = scl_out;
    sda_out_next       = sda_out;
    ack_fail_next      = ack_fail;
    rx_hold_next       = rx_hold;
    done               = 1'b0;

    if (phase == PH_IDLE) begin
      phase_ticks_next = 3'd0;
      unique case (mode)
        CMD_START: begin
          scl_out_next    = 1'b1;
          sda_out_next    = 1'b1;
          phase_next      = PH_S1;
          active_cmd_next = CMD_START;
        end
        CMD_STOP: begin
          sda_out_next    = 1'b0;
          scl_out_next    = 1'b0;
          phase_next      = PH_PA;
          active_cmd_next = CMD_STOP;
        end
        CMD_WRITE: begin
          scl_out_next    = 1'b0;
          shift_data_next = tx_byte;
          bit_index_next  = 4'd0;
          phase_next      = PH_WSET;
          active_cmd_next = CMD_WRITE;
        end
        CMD_WAIT: begin
          sda_out_next       = 1'b1;
          scl_out_next       = 1'b0;
          timeout_ticks_next = 8'd0;
          ack_fail_next      = 1'b0;
          phase_next         = PH_ALOW;
          active_cmd_next    = CMD_WAIT;
        end
        CMD_READ: begin
          sda_out_next    = 1'b1;
          scl_out_next    = 1'b0;
          shift_data_next = 8'd0;
          bit_index_next  = 4'd0;
          ack_choice_next = send_ack;
          phase_next      = PH_RLOW;
          active_cmd_next = CMD_READ;
        end
        default: begin
        end
      endcase
    end else if (phase == PH_APOLL) begin
      // Count released ticks; stop the bus once past the limit
      if (sda_level) begin
        timeout_ticks_next = timeout_inc;
        if (timeout_inc > ack_timeout_limit) begin
          ack_fail_next    = 1'b1;
          sda_out_next     = 1'b0;
          scl_out_next     = 1'b0;
          active_cmd_next  = CMD_STOP;
          phase_next       = PH_PA;
          phase_ticks_next = 3'd0;
        end
      end else begin
        phase_next       = PH_AHOLD;
        phase_ticks_next = 3'd0;
      end
    end else begin
      phase_ticks_next = ticks_inc;
      if (ticks_inc >= phase_length(phase)) begin
        phase_ticks_next = 3'd0;
        unique case (phase)
          PH_S1: begin
            sda_out_next = 1'b0;
            phase_next   = PH_S2;
          end
          PH_S2: begin
            scl_out_next = 1'b0;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_PA: begin
            scl_out_next = 1'b1;
            phase_next   = PH_PB;
          end
          PH_PB: begin
            sda_out_next = 1'b1;
            phase_next   = PH_PC;
          end
          PH_PC: begin
            scl_out_next = 1'b1;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_WSET: begin
            // Present the next data bit, or the ack bit after a read
            if (active_cmd == CMD_READ) begin
              sda_out_next = ~ack_choice;
            end else begin
              sda_out_next    = shift_data[7];
              shift_data_next = {shift_data[6:0], 1'b0};
            end
            phase_next = PH_WPRE;
          end
          PH_WPRE: begin
            scl_out_next = 1'b1;
            phase_next   = PH_WHIGH;
          end
          PH_WHIGH: begin
            scl_out_next   = 1'b0;
            bit_index_next = bit_inc;
            if (active_cmd == CMD_READ || bit_inc >= BYTE_BITS) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next = PH_WSET;
            end
          end
          PH_ALOW: begin
            scl_out_next = 1'b1;
            phase_next   = PH_APRE;
          end
          PH_APRE: begin
            phase_next = PH_APOLL;
          end
          PH_AHOLD: begin
            scl_out_next = 1'b0;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_RLOW: begin
            scl_out_next = 1'b1;
            phase_next   = PH_RPRE;
          end
          PH_RPRE: begin
            shift_data_next = {shift_data[6:0], sda_level};
            phase_next      = PH_RPOST;
          end
          PH_RPOST: begin
            scl_out_next   = 1'b0;
            bit_index_next = bit_inc;
            if (bit_inc >= BYTE_BITS) begin
              rx_hold_next = shift_data;
              phase_next   = PH_WSET;
            end else begin
              phase_next = PH_RLOW;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Hold the timeout limit
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_limit <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ack_timeout_limit <= cfg_data;
    end
  end

  // Update sequencer state on each taken tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      active_cmd    <= CMD_NONE;
      phase_ticks   <= 3'd0;
      bit_index     <= 4'd0;
      shift_data    <= 8'd0;
      timeout_ticks <= 8'd0;
      ack_choice    <= 1'b0;
      scl_out       <= 1'b1;
      sda_out       <= 1'b1;
      ack_fail      <= 1'b0;
      rx_hold       <= 8'd0;
    end else if (take) begin
      phase         <= phase_next;
      active_cmd    <= active_cmd_next;
      phase_ticks   <= phase_ticks_next;
      bit_index     <= bit_index_next;
      shift_data    <= shift_data_next;
      timeout_ticks <= timeout_ticks_next;
      ack_choice    <= ack_choice_next;
      scl_out       <= scl_out_next;
      sda_out       <= sda_out_next;
      ack_fail      <= ack_fail_next;
      rx_hold       <= rx_hold_next;
    end
  end

  // Result register: load on a taken tick, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {3'b000, ack_fail_next, rx_hold_next, done,
                  (phase_next != PH_IDLE), sda_out_next, scl_out_next};
    end
  end

endmodule

`default_nettype wire
